// File: design/acm_pkg.sv
// shared constants for the aho-corasick matcher
`default_nettype none
package acm_pkg;
    localparam int MAX_NODES_DEF = 1024;
    localparam int ALPHABET_DEF  = 26;
    localparam logic [7:0] SYM_BASE = 8'h61;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_PAT   = 2'd1;
    localparam logic [1:0] KIND_BUILD = 2'd2;
    localparam logic [1:0] KIND_TEXT  = 2'd3;

    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_FULL = 2'd1;
    localparam logic [1:0] ERR_SYM  = 2'd2;

    localparam int NODE_W = 10;
endpackage
`default_nettype wire

// File: design/acm_ram.sv
// generic single-port-write, one-read synchronous ram with registered read
`default_nettype none
module acm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: design/aho_corasick_matcher.sv
// top level of the aho-corasick matcher
// One beat in, one beat out, one item at a time. Node state lives in synchronous
// rams (child table with one row per node, link and mark rams, queue); each
// read is registered. A clear wipes the root row; a symbol outside the
// alphabet gives an error result; a pattern character reads the child of the
// cursor and, when there is none, creates a node and wipes its row, or reports
// the trie full; a text character follows failure links until it finds a
// child or reaches the root. A build walks every node and every symbol: the
// root row first, then each queued node, linking each child through its
// failure walk and dict link. After reset the root row is wiped, during which
// no beat is taken. The result waits in an output register and the next beat
// is taken only after the result has been taken.
`default_nettype none
module aho_corasick_matcher
    import acm_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int ALPHABET  = ALPHABET_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [1:0]            kind,
    input  wire logic [7:0]            symbol,
    input  wire logic                  last,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [NODE_W-1:0]          node,
    output logic                       is_pattern_end,
    output logic [NODE_W-1:0]          dict_suffix,
    output logic [1:0]                 error
);
    localparam int NW = $clog2(MAX_NODES);
    localparam int SW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int CW = NW + 1;
    localparam int AW = $clog2(MAX_NODES * ALPHABET);

    localparam logic [4:0] ST_WIPE   = 5'd0;
    localparam logic [4:0] ST_IDLE   = 5'd1;
    localparam logic [4:0] ST_PRD    = 5'd2;
    localparam logic [4:0] ST_PCHK   = 5'd3;
    localparam logic [4:0] ST_PNEW   = 5'd4;
    localparam logic [4:0] ST_PMARK  = 5'd5;
    localparam logic [4:0] ST_TRD    = 5'd6;
    localparam logic [4:0] ST_TCHK   = 5'd7;
    localparam logic [4:0] ST_TFAIL  = 5'd8;
    localparam logic [4:0] ST_TRES   = 5'd9;
    localparam logic [4:0] ST_TRES2  = 5'd10;
    localparam logic [4:0] ST_DONE   = 5'd11;
    localparam logic [4:0] ST_BROOT  = 5'd12;
    localparam logic [4:0] ST_BROOTC = 5'd13;
    localparam logic [4:0] ST_BPOP   = 5'd14;
    localparam logic [4:0] ST_BPOPW  = 5'd15;
    localparam logic [4:0] ST_BFU    = 5'd16;
    localparam logic [4:0] ST_BKID   = 5'd17;
    localparam logic [4:0] ST_BKIDC  = 5'd18;
    localparam logic [4:0] ST_BFRD   = 5'd19;
    localparam logic [4:0] ST_BFCHK  = 5'd20;
    localparam logic [4:0] ST_BFLNK  = 5'd21;
    localparam logic [4:0] ST_BDICT  = 5'd22;
    localparam logic [4:0] ST_BDICT2 = 5'd23;
    localparam logic [4:0] ST_BNEXT  = 5'd24;

    logic [4:0] state_reg, state_next;

    // rams
    logic          ch_we;  logic [AW-1:0] ch_wa, ch_ra; logic [NW:0] ch_wd, ch_rd;
    logic          mk_we;  logic [NW-1:0] mk_wa, mk_ra; logic mk_wd, mk_rd;
    logic          fl_we;  logic [NW-1:0] fl_wa, fl_ra, fl_wd, fl_rd;
    logic          dl_we;  logic [NW-1:0] dl_wa, dl_ra, dl_wd, dl_rd;
    logic          q_we;   logic [NW-1:0] q_wa, q_ra, q_wd, q_rd;

    acm_ram #(.WIDTH(NW+1), .DEPTH(MAX_NODES*ALPHABET)) u_child (.clk, .we(ch_we),
        .waddr(ch_wa), .wdata(ch_wd), .raddr(ch_ra), .rdata(ch_rd));
    acm_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_mark (.clk, .we(mk_we),
        .waddr(mk_wa), .wdata(mk_wd), .raddr(mk_ra), .rdata(mk_rd));
    acm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_fail (.clk, .we(fl_we),
        .waddr(fl_wa), .wdata(fl_wd), .raddr(fl_ra), .rdata(fl_rd));
    acm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_dict (.clk, .we(dl_we),
        .waddr(dl_wa), .wdata(dl_wd), .raddr(dl_ra), .rdata(dl_rd));
    acm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue (.clk, .we(q_we),
        .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));

    // control and working registers
    logic [CW-1:0] count_reg, count_next;
    logic [NW-1:0] cursor_reg, cursor_next;
    logic [NW-1:0] scan_reg, scan_next;
    logic [SW-1:0] sym_reg, sym_next;
    logic          last_reg, last_next;
    logic [NW-1:0] u_reg, u_next;     // node being walked
    logic [NW-1:0] v_reg, v_next;     // node being linked / reached
    logic [NW-1:0] fu_reg, fu_next;   // failure of queue head
    logic [SW-1:0] wsym_reg, wsym_next; // wipe / build symbol counter
    logic [NW-1:0] wnode_reg, wnode_next;
    logic [CW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [CW-1:0] steps_reg, steps_next;
    logic [NW-1:0] f_reg, f_next;
    logic          ov_reg, ov_next;
    logic [NW-1:0] on_reg, on_next, od_reg, od_next;
    logic          oe_reg, oe_next;
    logic [1:0]    oerr_reg, oerr_next;
    logic [4:0]    ret_reg, ret_next;  // state after wipe

    logic [7:0]  sym_raw;
    logic [NW:0] kid;
    assign sym_raw = symbol - SYM_BASE;
    assign kid = ch_rd;

    function automatic logic [AW-1:0] caddr(input logic [NW-1:0] n, input logic [SW-1:0] s);
        logic [AW+SW-1:0] p;
        p = ({{(AW+SW-NW){1'b0}}, n} * (AW+SW)'(ALPHABET)) + {{AW{1'b0}}, s};
        return p[AW-1:0];
    endfunction

    assign in_ready = (state_reg == ST_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign node = NODE_W'(on_reg);
    assign dict_suffix = NODE_W'(od_reg);
    assign is_pattern_end = oe_reg;
    assign error = oerr_reg;

    always_comb
    begin
        state_next = state_reg; count_next = count_reg; cursor_next = cursor_reg;
        scan_next = scan_reg; sym_next = sym_reg; last_next = last_reg;
        u_next = u_reg; v_next = v_reg; fu_next = fu_reg; wsym_next = wsym_reg;
        wnode_next = wnode_reg; head_next = head_reg; tail_next = tail_reg;
        steps_next = steps_reg; f_next = f_reg; ov_next = ov_reg; on_next = on_reg;
        od_next = od_reg; oe_next = oe_reg; oerr_next = oerr_reg; ret_next = ret_reg;
        ch_we = 1'b0; ch_wa = caddr(wnode_reg, wsym_reg); ch_wd = '0;
        ch_ra = caddr(u_reg, sym_reg);
        mk_we = 1'b0; mk_wa = v_reg; mk_wd = 1'b0; mk_ra = v_reg;
        fl_we = 1'b0; fl_wa = v_reg; fl_wd = '0; fl_ra = u_reg;
        dl_we = 1'b0; dl_wa = v_reg; dl_wd = '0; dl_ra = f_reg;
        q_we = 1'b0; q_wa = tail_reg[NW-1:0]; q_wd = v_reg; q_ra = head_reg[NW-1:0];
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            // wipe one child row, then clear node mark and links
            ST_WIPE:
            begin
                ch_we = 1'b1;
                if (wsym_reg == SW'(ALPHABET - 1))
                begin
                    wsym_next = '0;
                    mk_we = 1'b1; mk_wa = wnode_reg;
                    fl_we = 1'b1; fl_wa = wnode_reg;
                    dl_we = 1'b1; dl_wa = wnode_reg;
                    state_next = ret_reg;
                end
                else
                begin
                    wsym_next = wsym_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    sym_next = sym_raw[SW-1:0];
                    last_next = last;
                    on_next = '0; od_next = '0; oe_next = 1'b0; oerr_next = ERR_OK;
                    priority if (kind == KIND_CLEAR)
                    begin
                        count_next = CW'(1); cursor_next = '0; scan_next = '0;
                        wnode_next = '0; wsym_next = '0; ret_next = ST_DONE;
                        state_next = ST_WIPE;
                    end
                    else if (kind == KIND_BUILD)
                    begin
                        head_next = '0; tail_next = '0; wsym_next = '0;
                        fl_we = 1'b1; fl_wa = '0; dl_we = 1'b1; dl_wa = '0;
                        state_next = ST_BROOT;
                    end
                    else if ({24'd0, sym_raw} >= ALPHABET)
                    begin
                        oerr_next = ERR_SYM; state_next = ST_DONE;
                    end
                    else if (kind == KIND_PAT)
                    begin
                        u_next = cursor_reg; state_next = ST_PRD;
                    end
                    else
                    begin
                        u_next = scan_reg; steps_next = '0; state_next = ST_TRD;
                    end
                end
            end
            // pattern: read child of cursor
            ST_PRD:
            begin
                state_next = ST_PCHK;
            end
            ST_PCHK:
            begin
                if (kid == '0)
                begin
                    if (count_reg >= CW'(MAX_NODES))
                    begin
                        oerr_next = ERR_FULL; state_next = ST_DONE;
                    end
                    else
                    begin
                        v_next = count_reg[NW-1:0];
                        count_next = count_reg + 1'b1;
                        ch_we = 1'b1; ch_wa = caddr(u_reg, sym_reg);
                        ch_wd = {1'b0, count_reg[NW-1:0]};
                        wnode_next = count_reg[NW-1:0]; wsym_next = '0;
                        ret_next = ST_PNEW; state_next = ST_WIPE;
                    end
                end
                else
                begin
                    v_next = kid[NW-1:0]; state_next = ST_PNEW;
                end
            end
            // pattern: set mark on the last character, read the mark
            ST_PNEW:
            begin
                if (last_reg)
                begin
                    mk_we = 1'b1; mk_wd = 1'b1; cursor_next = '0;
                end
                else
                begin
                    cursor_next = v_reg;
                end
                state_next = ST_PMARK;
            end
            // the read in the marking cycle still sees the old mark
            ST_PMARK:
            begin
                on_next = v_reg; oe_next = last_reg ? 1'b1 : mk_rd; state_next = ST_DONE;
            end
            // text: failure walk
            ST_TRD:
            begin
                state_next = ST_TCHK;
            end
            ST_TCHK:
            begin
                if (u_reg == '0 || kid != '0 || steps_reg >= CW'(MAX_NODES))
                begin
                    v_next = kid[NW-1:0]; f_next = kid[NW-1:0];
                    state_next = ST_TRES;
                end
                else
                begin
                    state_next = ST_TFAIL;
                end
            end
            ST_TFAIL:
            begin
                u_next = fl_rd; steps_next = steps_reg + 1'b1; state_next = ST_TRD;
            end
            ST_TRES:
            begin
                state_next = ST_TRES2;
            end
            ST_TRES2:
            begin
                on_next = v_reg; oe_next = mk_rd; od_next = dl_rd;
                scan_next = last_reg ? '0 : v_reg;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!ov_reg)
                begin
                    ov_next = 1'b1; state_next = ST_IDLE;
                end
            end
            // build: children of root
            ST_BROOT:
            begin
                ch_ra = caddr('0, wsym_reg); state_next = ST_BROOTC;
            end
            ST_BROOTC:
            begin
                if (kid != '0)
                begin
                    q_we = 1'b1; q_wd = kid[NW-1:0];
                    tail_next = tail_reg + 1'b1;
                    fl_we = 1'b1; fl_wa = kid[NW-1:0];
                    dl_we = 1'b1; dl_wa = kid[NW-1:0];
                end
                if (wsym_reg == SW'(ALPHABET - 1))
                begin
                    state_next = ST_BPOP;
                end
                else
                begin
                    wsym_next = wsym_reg + 1'b1; state_next = ST_BROOT;
                end
            end
            ST_BPOP:
            begin
                if (head_reg >= tail_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_BPOPW;
                end
            end
            ST_BPOPW:
            begin
                u_next = q_rd; head_next = head_reg + 1'b1; wsym_next = '0;
                state_next = ST_BFU;
            end
            ST_BFU:
            begin
                state_next = ST_BKID;
            end
            ST_BKID:
            begin
                fu_next = fl_rd;
                ch_ra = caddr(u_reg, wsym_reg); state_next = ST_BKIDC;
            end
            ST_BKIDC:
            begin
                if (kid != '0 && tail_reg < CW'(MAX_NODES))
                begin
                    v_next = kid[NW-1:0];
                    q_we = 1'b1; q_wd = kid[NW-1:0];
                    tail_next = tail_reg + 1'b1;
                    f_next = fu_reg; steps_next = '0;
                    state_next = ST_BFRD;
                end
                else
                begin
                    state_next = ST_BNEXT;
                end
            end
            // build: failure walk from fail(u) on symbol
            ST_BFRD:
            begin
                ch_ra = caddr(f_reg, wsym_reg); fl_ra = f_reg; state_next = ST_BFCHK;
            end
            ST_BFCHK:
            begin
                if (f_reg == '0 || kid != '0 || steps_reg >= CW'(MAX_NODES))
                begin
                    f_next = kid[NW-1:0]; state_next = ST_BFLNK;
                end
                else
                begin
                    f_next = fl_rd; steps_next = steps_reg + 1'b1; state_next = ST_BFRD;
                end
            end
            ST_BFLNK:
            begin
                fl_we = 1'b1; fl_wd = f_reg; mk_ra = f_reg;
                state_next = ST_BDICT;
            end
            ST_BDICT:
            begin
                state_next = ST_BDICT2;
            end
            ST_BDICT2:
            begin
                dl_we = 1'b1; dl_wd = mk_rd ? f_reg : dl_rd;
                state_next = ST_BNEXT;
            end
            ST_BNEXT:
            begin
                if (wsym_reg == SW'(ALPHABET - 1))
                begin
                    state_next = ST_BPOP;
                end
                else
                begin
                    wsym_next = wsym_reg + 1'b1; state_next = ST_BKID;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // text result reads mark and dict link of reached node
        if (state_reg == ST_TRES)
        begin
            mk_ra = v_reg; dl_ra = v_reg;
        end
        if (state_reg == ST_BDICT)
        begin
            mk_ra = f_reg; dl_ra = f_reg;
        end
        if (state_reg == ST_TFAIL || state_reg == ST_TRD)
        begin
            fl_ra = u_reg;
        end
    end

    // text read step also reads failure link of u (already by default)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_WIPE; count_reg <= CW'(1); cursor_reg <= '0; scan_reg <= '0;
            wsym_reg <= '0; wnode_reg <= '0; ret_reg <= ST_IDLE; ov_reg <= 1'b0;
            head_reg <= '0; tail_reg <= '0; steps_reg <= '0;
        end
        else
        begin
            state_reg <= state_next; count_reg <= count_next; cursor_reg <= cursor_next;
            scan_reg <= scan_next; wsym_reg <= wsym_next; wnode_reg <= wnode_next;
            ret_reg <= ret_next; ov_reg <= ov_next; head_reg <= head_next;
            tail_reg <= tail_next; steps_reg <= steps_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sym_reg <= sym_next; last_reg <= last_next; u_reg <= u_next; v_reg <= v_next;
        fu_reg <= fu_next; f_reg <= f_next; on_reg <= on_next; od_reg <= od_next;
        oe_reg <= oe_next; oerr_reg <= oerr_next;
    end
endmodule
`default_nettype wire

// File: design/acm_checker.sv
// port-level checks for the aho-corasick matcher, bound to the top level
`default_nettype none
module acm_checker
    import acm_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_ready,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire logic [NODE_W-1:0] node,
    input wire logic             is_pattern_end,
    input wire logic [NODE_W-1:0] dict_suffix,
    input wire logic [1:0]       error
);
    // an accepted beat blocks input until its result is out
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready) else $error("input taken twice");
    // no input taken while a result waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input ready with result pending");
    // error results carry zero payload
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error != ERR_OK |-> node == '0 && !is_pattern_end && dict_suffix == '0)
        else $error("error beat with payload");
    // error code never out of range
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> error != 2'd3) else $error("bad error code");
    // result holds while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(node)) else $error("result dropped");
endmodule

bind aho_corasick_matcher acm_checker u_acm_checker (.clk, .rst_n, .in_valid, .in_ready,
    .out_valid, .out_ready, .node, .is_pattern_end, .dict_suffix, .error);
`default_nettype wire
